@@ rtl/lfb_pkg.sv @@
// Shared constants, field widths and controller/datapath interface types.
`timescale 1ns / 1ps
package lfb_pkg;

  localparam int TABLE_WORDS = 521;
  localparam int SHORT_LAG   = 32;
  localparam int SEED_WORDS  = 17;

  localparam int LAG_USED    = (SHORT_LAG < TABLE_WORDS) ? SHORT_LAG : (TABLE_WORDS - 1);
  localparam int TABLE_BYTES = TABLE_WORDS * 4;

  localparam int ADDR_W = $clog2(TABLE_WORDS);
  localparam int POS_W  = $clog2(TABLE_BYTES + 1);

  localparam int MODE_W     = 2;
  localparam int SEED_IDX_W = 5;
  localparam int WORD_W     = 32;
  localparam int SKIP_W     = 20;
  localparam int BYTE_W     = 8;
  localparam int REM_W      = SKIP_W + 1;

  localparam int IN_FIELDS_W = SEED_IDX_W + WORD_W + SKIP_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((BYTE_W + 7) / 8) * 8;

  localparam int EXPAND_PASSES = 4;
  localparam int PASS_W        = $clog2(EXPAND_PASSES + 1);

  localparam int EXP_SHL = 23;
  localparam int EXP_SHR = 9;
  localparam logic [WORD_W-1:0] MIX_KEEP = 32'hFF00FFFF;
  localparam logic [WORD_W-1:0] MIX_MOVE = 32'h00FF0000;

  localparam logic [MODE_W-1:0] MODE_SEED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EMIT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SKIP = 2'd2;

  typedef struct packed {
    logic seed_wr;
    logic idx_clr;
    logic idx_inc;
    logic ld_rd;
    logic ld_wr;
    logic exp_wr;
    logic fwd_rd;
    logic fwd_wr;
    logic emit_rd;
    logic out_load;
    logic pos_clr;
    logic pos_inc;
    logic pos_from_rem;
    logic rem_load;
    logic rem_sub;
  } lfb_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] in_mode;
    logic              in_seed_ok;
    logic              in_seed_last;
    logic              ld_last;
    logic              idx_last;
    logic              pos_wrap;
    logic              rem_wrap;
    logic              out_free;
  } lfb_sts_t;

endpackage

@@ rtl/lfb_ctrl.sv @@
// Sequencing state machine: seeding, expansion, forward passes, emit and skip.
`timescale 1ns / 1ps
module lfb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lfb_pkg::lfb_sts_t sts_i,
  output lfb_pkg::lfb_cmd_t cmd_o
);
  import lfb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_EXP,
    ST_FWD_RD,
    ST_FWD_WR,
    ST_EMIT,
    ST_SKIP
  } state_e;

  state_e              state_q, state_d;
  logic [PASS_W-1:0]   passes_q, passes_d;
  logic                skip_q, skip_d;

  always_comb begin
    state_d    = state_q;
    passes_d   = passes_q;
    skip_d     = skip_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (sts_i.in_mode)
            MODE_SEED: begin
              if (sts_i.in_seed_ok) begin
                cmd_o.seed_wr = 1'b1;
                if (sts_i.in_seed_last) begin
                  cmd_o.idx_clr = 1'b1;
                  cmd_o.pos_clr = 1'b1;
                  passes_d      = PASS_W'(EXPAND_PASSES);
                  skip_d        = 1'b0;
                  state_d       = ST_LD_RD;
                end
              end
            end
            MODE_EMIT: begin
              cmd_o.emit_rd = 1'b1;
              state_d       = ST_EMIT;
            end
            MODE_SKIP: begin
              cmd_o.rem_load = 1'b1;
              state_d        = ST_SKIP;
            end
            default: ;
          endcase
        end
      end
      ST_LD_RD: begin
        cmd_o.ld_rd = 1'b1;
        state_d     = ST_LD_WR;
      end
      ST_LD_WR: begin
        cmd_o.ld_wr   = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d       = sts_i.ld_last ? ST_EXP : ST_LD_RD;
      end
      ST_EXP: begin
        cmd_o.exp_wr = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_FWD_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_FWD_RD: begin
        cmd_o.fwd_rd = 1'b1;
        state_d      = ST_FWD_WR;
      end
      ST_FWD_WR: begin
        cmd_o.fwd_wr = 1'b1;
        state_d      = ST_FWD_RD;
        if (sts_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          if (passes_q == PASS_W'(1)) begin
            state_d = skip_q ? ST_SKIP : ST_IDLE;
          end else begin
            passes_d = passes_q - PASS_W'(1);
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_EMIT: begin
        // hold the read word until the output register can take the byte
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.pos_wrap) begin
            cmd_o.pos_clr = 1'b1;
            cmd_o.idx_clr = 1'b1;
            passes_d      = PASS_W'(1);
            skip_d        = 1'b0;
            state_d       = ST_FWD_RD;
          end else begin
            cmd_o.pos_inc = 1'b1;
            state_d       = ST_IDLE;
          end
        end
      end
      ST_SKIP: begin
        if (sts_i.rem_wrap) begin
          cmd_o.rem_sub = 1'b1;
          cmd_o.idx_clr = 1'b1;
          passes_d      = PASS_W'(1);
          skip_d        = 1'b1;
          state_d       = ST_FWD_RD;
        end else begin
          cmd_o.pos_from_rem = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      passes_q <= '0;
      skip_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      passes_q <= passes_d;
      skip_q   <= skip_d;
    end
  end

endmodule

@@ rtl/lfb_datapath.sv @@
// Word table memory, seed window, position counters and output register.
`timescale 1ns / 1ps
module lfb_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lfb_pkg::lfb_cmd_t                  cmd_i,
  output lfb_pkg::lfb_sts_t                  sts_o,
  input  logic [lfb_pkg::MODE_W-1:0]         in_mode_i,
  input  logic [lfb_pkg::SEED_IDX_W-1:0]     in_seed_index_i,
  input  logic [lfb_pkg::WORD_W-1:0]         in_seed_word_i,
  input  logic [lfb_pkg::SKIP_W-1:0]         in_skip_count_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [lfb_pkg::BYTE_W-1:0]         out_byte_o
);
  import lfb_pkg::*;

  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] x);
    mix_word = (x & MIX_KEEP) | ((x >> 2) & MIX_MOVE);
  endfunction

  logic [WORD_W-1:0] mem [TABLE_WORDS];
  logic [WORD_W-1:0] rd_a_q, rd_b_q;
  logic [WORD_W-1:0] win_q [SEED_WORDS];

  logic [ADDR_W-1:0] idx_q;
  logic [POS_W-1:0]  pos_q;
  logic [REM_W-1:0]  rem_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;

  logic [ADDR_W-1:0] partner;
  logic [ADDR_W-1:0] rd_addr_a;
  logic              rd_en_a;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] exp_word;
  logic [BYTE_W-1:0] sel_byte;

  // lag partner: wraps to the tail of the table for the first words
  assign partner = (idx_q < ADDR_W'(LAG_USED)) ? idx_q + ADDR_W'(TABLE_WORDS - LAG_USED)
                                              : idx_q - ADDR_W'(LAG_USED);

  assign exp_word = (win_q[0] << EXP_SHL) ^ (win_q[1] >> EXP_SHR) ^ win_q[SEED_WORDS-1];

  assign rd_en_a   = cmd_i.ld_rd | cmd_i.fwd_rd | cmd_i.emit_rd;
  assign rd_addr_a = cmd_i.emit_rd ? pos_q[ADDR_W+1:2] : idx_q;
  assign wr_en     = cmd_i.seed_wr | cmd_i.ld_wr | cmd_i.exp_wr | cmd_i.fwd_wr;

  always_comb begin
    wr_addr = idx_q;
    wr_data = rd_a_q ^ rd_b_q;
    if (cmd_i.seed_wr) begin
      wr_addr = ADDR_W'(in_seed_index_i);
      wr_data = in_seed_word_i;
    end else if (cmd_i.ld_wr) begin
      wr_data = mix_word(rd_a_q);
    end else if (cmd_i.exp_wr) begin
      wr_data = mix_word(exp_word);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en_a) begin
      rd_a_q <= mem[rd_addr_a];
    end
    if (cmd_i.fwd_rd) begin
      rd_b_q <= mem[partner];
    end
  end

  // shift window of the last seed-length words, unmixed
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_wr || cmd_i.exp_wr) begin
      for (int k = 0; k < SEED_WORDS - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[SEED_WORDS-1] <= cmd_i.ld_wr ? rd_a_q : exp_word;
    end
  end

  always_comb begin
    case (pos_q[1:0])
      2'd0:    sel_byte = rd_a_q[31:24];
      2'd1:    sel_byte = rd_a_q[23:16];
      2'd2:    sel_byte = rd_a_q[15:8];
      default: sel_byte = rd_a_q[7:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      pos_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + ADDR_W'(1);
      end
      if (cmd_i.pos_clr) begin
        pos_q <= '0;
      end else if (cmd_i.pos_inc) begin
        pos_q <= pos_q + POS_W'(1);
      end else if (cmd_i.pos_from_rem) begin
        pos_q <= rem_q[POS_W-1:0];
      end
      if (cmd_i.rem_load) begin
        rem_q <= REM_W'(pos_q) + REM_W'(in_skip_count_i);
      end else if (cmd_i.rem_sub) begin
        rem_q <= rem_q - REM_W'(TABLE_BYTES);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_byte_q <= sel_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  assign sts_o.in_mode      = in_mode_i;
  assign sts_o.in_seed_ok   = in_seed_index_i < SEED_IDX_W'(SEED_WORDS);
  assign sts_o.in_seed_last = in_seed_index_i == SEED_IDX_W'(SEED_WORDS - 1);
  assign sts_o.ld_last      = idx_q == ADDR_W'(SEED_WORDS - 1);
  assign sts_o.idx_last     = idx_q == ADDR_W'(TABLE_WORDS - 1);
  assign sts_o.pos_wrap     = pos_q == POS_W'(TABLE_BYTES - 1);
  assign sts_o.rem_wrap     = rem_q >= REM_W'(TABLE_BYTES);
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < POS_W'(TABLE_BYTES))
    else $error("byte position left the table");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output byte overwritten before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exp_wr || cmd_i.fwd_wr || cmd_i.ld_wr) |-> idx_q <= ADDR_W'(TABLE_WORDS - 1))
    else $error("table write index out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pos_from_rem |-> rem_q < REM_W'(TABLE_BYTES))
    else $error("skip remainder not reduced below one table");

endmodule

@@ rtl/lagged_fibonacci_byte_stream.sv @@
// Top level of the XOR lagged-Fibonacci byte stream generator.
`timescale 1ns / 1ps
// Takes one word at a time and works on it to the end before taking the next.
// An emit word reads the table, then loads the byte into the output register
// once that register is free; a seed write to indices 0..15 is one table write
// and a skip adds the count to the byte position. Writing seed index 16 starts
// the table build: each seed word is read and written back mixed, the rest of
// the table is expanded, then four forward passes read each table word with its
// lag partner and write their XOR back. Each wrap of the byte position past the
// end of the table, on emit or skip, adds one forward pass; the single table
// memory has one write and two read ports. Emitting or skipping before all 17
// seed words are written returns undefined bytes.
module lagged_fibonacci_byte_stream (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [4:0] seed_index, [36:5] seed_word, [56:37] skip_count, rest zero
  input  logic [lfb_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // [1:0] mode
  input  logic [lfb_pkg::MODE_W-1:0]       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [7:0] stream_byte
  output logic [lfb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);
  import lfb_pkg::*;

  lfb_cmd_t          cmd;
  lfb_sts_t          sts;
  logic [BYTE_W-1:0] out_byte;

  lfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfb_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_mode_i       (s_axis_tuser_i),
    .in_seed_index_i (s_axis_tdata_i[SEED_IDX_W-1:0]),
    .in_seed_word_i  (s_axis_tdata_i[SEED_IDX_W +: WORD_W]),
    .in_skip_count_i (s_axis_tdata_i[SEED_IDX_W + WORD_W +: SKIP_W]),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .out_byte_o      (out_byte)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'(out_byte);

endmodule
